// File: sv/mac_pkg.sv
// Shared types and constants for the moving average crossover detector.
package mac_pkg;

	localparam int PRICE_W    = 24;
	localparam int DATE_W     = 27;
	localparam int SHORT_W    = 8;
	localparam int LONG_W     = 9;
	localparam int CFG_DATA_W = 9;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SHORT_LEN = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LONG_LEN  = CFG_IDX_W'(1);

	localparam logic [SHORT_W-1:0] SHORT_LEN_RST = SHORT_W'(50);
	localparam logic [LONG_W-1:0]  LONG_LEN_RST  = LONG_W'(200);

	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic [DATE_W-1:0]  date;
	} sample_t;

	typedef struct packed {
		logic              cross_up;
		logic              warmed;
		logic              short_above;
		logic [DATE_W-1:0] date_out;
	} result_t;

	typedef struct packed {
		logic advance;
		logic clear;
		logic warmed;
		logic sub_short;
		logic sub_long;
		logic short_lt_long;
	} eval_ctl_t;

	typedef struct packed {
		logic cross_up;
		logic short_above;
	} eval_res_t;

endpackage

// File: sv/mac_hist.sv
// Price history memory: one write port, two registered read ports.
module mac_hist #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int DW    = 24
) (
	input  logic          clk,
	input  logic          access,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic [DW-1:0] rdata_a,
	output logic [DW-1:0] rdata_b
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_a_q;
	logic [DW-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (access) begin
			rdata_a_q   <= mem[raddr_a];
			rdata_b_q   <= mem[raddr_b];
			mem[waddr]  <= wdata;
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

// File: sv/mac_eval.sv
// Window sums, cross-multiplied average compare and crossover flag.
module mac_eval #(
	parameter int PW = 24,
	parameter int LW = 9
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mac_pkg::eval_ctl_t ctl,
	input  logic [PW-1:0]      price,
	input  logic [PW-1:0]      rd_short,
	input  logic [PW-1:0]      rd_long,
	input  logic [LW-1:0]      short_len,
	input  logic [LW-1:0]      long_len,
	output mac_pkg::eval_res_t res
);

	import mac_pkg::*;

	localparam int SW = PW + LW;
	localparam int PRW = SW + LW;

	logic [SW-1:0]  short_sum_q;
	logic [SW-1:0]  long_sum_q;
	logic           prev_below_q;
	logic           prev_valid_q;
	logic [PRW-1:0] prod_short;
	logic [PRW-1:0] prod_long;
	logic           gt;
	logic           lt;
	logic [SW-1:0]  drop_short;
	logic [SW-1:0]  drop_long;

	assign prod_short = PRW'(short_sum_q) * PRW'(long_len);
	assign prod_long  = PRW'(long_sum_q) * PRW'(short_len);
	assign gt = prod_short > prod_long;
	assign lt = prod_short < prod_long;

	assign drop_short = ctl.sub_short ? SW'(rd_short) : '0;
	assign drop_long  = ctl.sub_long ? SW'(rd_long) : '0;

	assign res.short_above = ctl.warmed && gt;
	assign res.cross_up    = ctl.warmed && gt && prev_valid_q && prev_below_q &&
		ctl.short_lt_long;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_sum_q  <= '0;
			long_sum_q   <= '0;
			prev_below_q <= 1'b0;
			prev_valid_q <= 1'b0;
		end else if (ctl.clear) begin
			short_sum_q  <= '0;
			long_sum_q   <= '0;
			prev_below_q <= 1'b0;
			prev_valid_q <= 1'b0;
		end else if (ctl.advance) begin
			short_sum_q <= short_sum_q - drop_short + SW'(price);
			long_sum_q  <= long_sum_q - drop_long + SW'(price);
			if (ctl.warmed) begin
				prev_below_q <= lt;
				prev_valid_q <= 1'b1;
			end
		end
	end

endmodule

// File: sv/moving_average_crossover_detector.sv
// Moving average crossover detector: takes one dated price word per cycle while the
// output is not stalled and returns one result word per price, registered in stage
// one and then in the output register. The history memory is read at the two window
// tails and written at the head in the cycle a word is accepted; stage one updates
// both running sums and compares the averages by cross-multiplication. Length register
// writes restart the windows; write registers only while no word is in flight.
module moving_average_crossover_detector #(
	parameter int MAX_WINDOW  = 256,
	parameter int PRICE_WIDTH = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_ready,
	input  mac_pkg::sample_t                  sample,
	output logic                              result_valid,
	input  logic                              result_ready,
	output mac_pkg::result_t                  result,
	input  logic                              cfg_we,
	input  logic [mac_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mac_pkg::CFG_DATA_W-1:0]    cfg_data
);

	import mac_pkg::*;

	localparam int AW = $clog2(MAX_WINDOW);
	localparam int LW = $clog2(MAX_WINDOW) + 1;
	localparam int CW = (LW > LONG_W) ? LW : LONG_W;
	localparam int PW = PRICE_WIDTH;

	logic [SHORT_W-1:0] short_len_q;
	logic [LONG_W-1:0]  long_len_q;
	logic               cfg_hit;

	logic [CW-1:0] short_x;
	logic [CW-1:0] long_x;
	logic [LW-1:0] short_eff;
	logic [LW-1:0] long_eff;
	logic [LW-1:0] need;

	logic [AW-1:0] wp_q;
	logic [LW-1:0] fill_q;
	logic [LW:0]   tail_s;
	logic [LW:0]   tail_l;
	logic [LW:0]   tail_s_w;
	logic [LW:0]   tail_l_w;
	logic [AW-1:0] raddr_s;
	logic [AW-1:0] raddr_l;

	logic [PW+PRICE_W-1:0] price_ext;
	logic [PW-1:0]         price_m;
	logic                  sample_fire;

	logic              valid_s1;
	logic [PW-1:0]     price_s1;
	logic [DATE_W-1:0] date_s1;
	logic              warmed_s1;
	logic              sub_short_s1;
	logic              sub_long_s1;
	logic              adv_s1;

	logic [PW-1:0] rd_short;
	logic [PW-1:0] rd_long;

	eval_ctl_t ctl;
	eval_res_t res;

	logic    result_valid_q;
	result_t result_q;

	// register file
	assign cfg_hit = cfg_we && ((cfg_index == REG_SHORT_LEN) || (cfg_index == REG_LONG_LEN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_len_q <= SHORT_LEN_RST;
			long_len_q  <= LONG_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SHORT_LEN: short_len_q <= cfg_data[SHORT_W-1:0];
				REG_LONG_LEN:  long_len_q  <= cfg_data[LONG_W-1:0];
				default: ;
			endcase
		end
	end

	// effective window lengths
	assign short_x = CW'(short_len_q);
	assign long_x  = CW'(long_len_q);
	assign short_eff = (short_x == '0) ? LW'(1) :
		(short_x > CW'(MAX_WINDOW)) ? LW'(MAX_WINDOW) : short_x[LW-1:0];
	assign long_eff = (long_x == '0) ? LW'(1) :
		(long_x > CW'(MAX_WINDOW)) ? LW'(MAX_WINDOW) : long_x[LW-1:0];
	assign need = (short_eff > long_eff) ? short_eff : long_eff;

	// window tail addresses
	assign tail_s   = (LW+1)'(wp_q) + (LW+1)'(MAX_WINDOW) - (LW+1)'(short_eff);
	assign tail_l   = (LW+1)'(wp_q) + (LW+1)'(MAX_WINDOW) - (LW+1)'(long_eff);
	assign tail_s_w = (tail_s >= (LW+1)'(MAX_WINDOW)) ? tail_s - (LW+1)'(MAX_WINDOW) : tail_s;
	assign tail_l_w = (tail_l >= (LW+1)'(MAX_WINDOW)) ? tail_l - (LW+1)'(MAX_WINDOW) : tail_l;
	assign raddr_s  = tail_s_w[AW-1:0];
	assign raddr_l  = tail_l_w[AW-1:0];

	assign price_ext = {{PW{1'b0}}, sample.price};
	assign price_m   = price_ext[PW-1:0];

	// handshake
	assign adv_s1       = valid_s1 && (!result_valid_q || result_ready);
	assign sample_ready = !valid_s1 || adv_s1;
	assign sample_fire  = sample_valid && sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (cfg_hit) begin
			fill_q <= '0;
		end else if (sample_fire) begin
			wp_q <= (wp_q == AW'(MAX_WINDOW - 1)) ? '0 : wp_q + AW'(1);
			if (fill_q != LW'(MAX_WINDOW)) begin
				fill_q <= fill_q + LW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_fire) begin
			price_s1     <= price_m;
			date_s1      <= sample.date;
			warmed_s1    <= fill_q >= need;
			sub_short_s1 <= fill_q >= short_eff;
			sub_long_s1  <= fill_q >= long_eff;
		end
	end

	mac_hist #(
		.DEPTH (MAX_WINDOW),
		.AW    (AW),
		.DW    (PW)
	) u_hist (
		.clk     (clk),
		.access  (sample_fire),
		.waddr   (wp_q),
		.wdata   (price_m),
		.raddr_a (raddr_s),
		.raddr_b (raddr_l),
		.rdata_a (rd_short),
		.rdata_b (rd_long)
	);

	assign ctl.advance       = adv_s1;
	assign ctl.clear         = cfg_hit;
	assign ctl.warmed        = warmed_s1;
	assign ctl.sub_short     = sub_short_s1;
	assign ctl.sub_long      = sub_long_s1;
	assign ctl.short_lt_long = short_eff < long_eff;

	mac_eval #(
		.PW (PW),
		.LW (LW)
	) u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.price     (price_s1),
		.rd_short  (rd_short),
		.rd_long   (rd_long),
		.short_len (short_eff),
		.long_len  (long_eff),
		.res       (res)
	);

	// output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv_s1) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_q.cross_up    <= res.cross_up;
			result_q.warmed      <= warmed_s1;
			result_q.short_above <= res.short_above;
			result_q.date_out    <= date_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// File: tb/moving_average_crossover_detector_test.sv
// Self-checking testbench for the moving average crossover detector.
`timescale 1ns / 100ps

module moving_average_crossover_detector_test;
	import mac_pkg::*;

	localparam int HISTORY_DEPTH = 256;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_CYCLES   = 400;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  sample_valid = 1'b0;
	logic                  sample_ready;
	sample_t               sample       = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	result_t               result;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	result_t pending_results[$];
	int      error_count   = 0;
	int      cycle_count   = 0;
	int      send_idle_pct = 0;
	int      stall_pct     = 0;
	bit      hold_request  = 1'b0;
	int      hold_left     = 0;

	logic [PRICE_W-1:0] price_log [HISTORY_DEPTH];
	logic [7:0]         head_ptr     = '0;
	logic [8:0]         fill_cnt     = '0;
	longint unsigned    short_total  = 0;
	longint unsigned    long_total   = 0;
	bit                 was_below    = 1'b0;
	bit                 was_compared = 1'b0;
	logic [SHORT_W-1:0] short_reg    = SHORT_LEN_RST;
	logic [LONG_W-1:0]  long_reg     = LONG_LEN_RST;

	int walk_price = 24'h800000;
	bit walk_up    = 1'b1;
	int walk_left  = 0;

	moving_average_crossover_detector u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_request) begin
			hold_left    = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			result_ready <= 1'b0;
			hold_left--;
		end else begin
			result_ready <= ($urandom_range(99, 0) >= stall_pct);
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result word, date_out %0d", result.date_out);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (result.cross_up !== want.cross_up) begin
					$error("cross_up expected %0d actual %0d", want.cross_up, result.cross_up);
					error_count++;
				end
				if (result.warmed !== want.warmed) begin
					$error("warmed expected %0d actual %0d", want.warmed, result.warmed);
					error_count++;
				end
				if (result.short_above !== want.short_above) begin
					$error("short_above expected %0d actual %0d", want.short_above,
						result.short_above);
					error_count++;
				end
				if (result.date_out !== want.date_out) begin
					$error("date_out expected %0d actual %0d", want.date_out, result.date_out);
					error_count++;
				end
			end
		end
	end

	function automatic int unsigned window_span(input int unsigned len);
		if (len == 0) return 1;
		if (len > HISTORY_DEPTH) return HISTORY_DEPTH;
		return len;
	endfunction

	function automatic result_t predict_crossover(input sample_t word);
		int unsigned     sl;
		int unsigned     ll;
		int unsigned     need;
		longint unsigned lhs;
		longint unsigned rhs;
		bit              warm;
		bit              above;
		bit              cross_hit;
		result_t         res;
		sl        = window_span(short_reg);
		ll        = window_span(long_reg);
		need      = (sl > ll) ? sl : ll;
		warm      = (fill_cnt >= need);
		above     = 1'b0;
		cross_hit = 1'b0;
		if (warm) begin
			lhs          = short_total * ll;
			rhs          = long_total * sl;
			above        = (lhs > rhs);
			cross_hit    = above && was_compared && was_below && (sl < ll);
			was_below    = (lhs < rhs);
			was_compared = 1'b1;
		end
		if (fill_cnt >= sl)
			short_total -= price_log[head_ptr - 8'(sl)];
		if (fill_cnt >= ll)
			long_total -= price_log[head_ptr - 8'(ll)];
		short_total += word.price;
		long_total  += word.price;
		price_log[head_ptr] = word.price;
		head_ptr++;
		if (fill_cnt < HISTORY_DEPTH)
			fill_cnt++;
		res.cross_up    = cross_hit;
		res.warmed      = warm;
		res.short_above = above;
		res.date_out    = word.date;
		return res;
	endfunction

	task automatic send_sample(input logic [PRICE_W-1:0] p, input logic [DATE_W-1:0] d);
		sample_t word;
		if ($urandom_range(99, 0) < send_idle_pct) begin
			sample_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
		end
		word.price = p;
		word.date  = d;
		sample_valid <= 1'b1;
		sample       <= word;
		do @(posedge clk); while (!sample_ready);
		pending_results.insert(pending_results.size(), predict_crossover(word));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		sample_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SHORT_LEN: begin
				short_reg = data[SHORT_W-1:0];
			end
			REG_LONG_LEN: begin
				long_reg = data[LONG_W-1:0];
			end
			default: begin
				return;
			end
		endcase
		fill_cnt     = '0;
		short_total  = 0;
		long_total   = 0;
		was_below    = 1'b0;
		was_compared = 1'b0;
	endtask

	task automatic write_windows(input logic [CFG_DATA_W-1:0] short_val,
			input logic [CFG_DATA_W-1:0] long_val);
		write_reg(REG_SHORT_LEN, short_val);
		write_reg(REG_LONG_LEN, long_val);
	endtask

	task automatic set_idling(input int sender_pct, input int receiver_pct);
		send_idle_pct = sender_pct;
		stall_pct     = receiver_pct;
	endtask

	task automatic feed_market(input int count);
		int unsigned        span;
		int                 roll;
		int                 move;
		logic [PRICE_W-1:0] p;
		span = window_span(long_reg);
		repeat (count) begin
			roll = $urandom_range(99, 0);
			if (walk_left == 0) begin
				walk_up   = 1'($urandom_range(1, 0));
				walk_left = $urandom_range(2 * span, 1);
			end
			walk_left--;
			move       = $urandom_range(2048, 0);
			walk_price = walk_up ? walk_price + move : walk_price - move;
			walk_price += int'($urandom_range(512, 0)) - 256;
			if (walk_price < 0)
				walk_price = 0;
			if (walk_price > 24'hFFFFFF)
				walk_price = 24'hFFFFFF;
			if (roll < 8)
				p = PRICE_W'($urandom_range(24'hFFFFFF, 0));
			else if (roll < 9)
				p = '0;
			else if (roll < 10)
				p = '1;
			else
				p = walk_price[PRICE_W-1:0];
			send_sample(p, DATE_W'($urandom_range(99991231, 0)));
		end
	endtask

	task automatic test_field_extremes();
		set_idling(0, 0);
		send_sample('0, '0);
		send_sample('1, 27'd99991231);
		send_sample(24'hAAAAAA, 27'h2AAAAAA);
		send_sample(24'h555555, 27'h5555555);
		send_sample(24'h000001, 27'd1);
		send_sample(24'hFFFFFE, 27'd20240229);
	endtask

	task automatic test_reset_windows();
		set_idling(0, 0);
		feed_market(260);
	endtask

	task automatic test_crossing_patterns();
		set_idling(0, 0);
		write_windows(9'd0, 9'd2);
		send_sample('1, 27'd19900101);
		send_sample('1, 27'd19900102);
		send_sample('0, 27'd19900103);
		send_sample('1, 27'd19900104);
		send_sample('0, 27'd19900105);
		send_sample('0, 27'd19900106);
		send_sample('1, 27'd19900107);
		send_sample(24'h000100, 27'd19900108);
	endtask

	task automatic test_ignored_index();
		write_reg(REG_SPARE_2, '1);
		write_reg(REG_SPARE_3, '0);
		send_sample(24'h000200, 27'd20000101);
		send_sample(24'h000100, 27'd20000102);
		send_sample(24'h000300, 27'd20000103);
		send_sample(24'h000100, 27'd20000104);
	endtask

	task automatic test_short_not_shorter();
		write_windows(9'd5, 9'd3);
		send_sample('1, 27'd20100101);
		send_sample('1, 27'd20100102);
		send_sample('0, 27'd20100103);
		send_sample('0, 27'd20100104);
		send_sample('0, 27'd20100105);
		send_sample('1, 27'd20100106);
		send_sample('1, 27'd20100107);
		send_sample('1, 27'd20100108);
	endtask

	task automatic test_sender_gaps();
		write_windows(9'd3, 9'd8);
		set_idling(56, 0);
		feed_market(200);
	endtask

	task automatic test_output_backpressure();
		write_windows(9'd2, 9'd5);
		set_idling(0, 56);
		hold_request = 1'b1;
		feed_market(200);
	endtask

	task automatic test_widest_windows();
		write_windows(9'h1FF, 9'h1FF);
		set_idling(21, 21);
		feed_market(280);
	endtask

	task automatic test_reversed_windows();
		write_windows(9'd7, 9'd3);
		set_idling(0, 0);
		feed_market(60);
	endtask

	task automatic test_minimum_windows();
		write_windows(9'd1, 9'd2);
		set_idling(0, 56);
		feed_market(100);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_field_extremes();
		test_reset_windows();
		test_crossing_patterns();
		test_ignored_index();
		test_short_not_shorter();
		test_sender_gaps();
		test_output_backpressure();
		test_widest_windows();
		test_reversed_windows();
		test_minimum_windows();
		sample_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
